// ===== rtl/btmx_pkg.sv =====
// Package for the binary trie maximum-xor block: sizes, node pool layout,
// operation and status codes, sequencer states and a key bit helper.
// No dependencies; used by binary_trie_max_xor.
`default_nettype none

package btmx_pkg;

  // Trie geometry
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned MAX_KEYS   = 1024;
  localparam int unsigned POOL_NODES = MAX_KEYS * KEY_BITS + 1;

  // Field widths of the stream items
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  // Node index width, node word width (two links) and level counter width
  localparam int unsigned NODE_AW = $clog2(POOL_NODES);
  localparam int unsigned NODE_W  = 2 * NODE_AW;
  localparam int unsigned LVL_W   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  typedef logic [NODE_AW-1:0] node_idx_t;
  typedef logic [LVL_W-1:0]   lvl_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LINK,
    S_ALLOC,
    S_DONE
  } state_e;

  // Bit lvl of the key; levels at or above the key width read as zero
  function automatic logic key_bit(logic [KEY_W-1:0] key, lvl_t lvl);
    logic [KEY_W-1:0] sh;
    sh = key >> lvl;
    return sh[0];
  endfunction

  // One-hot mask of level lvl within the result word, zero beyond it
  function automatic logic [KEY_W-1:0] lvl_mask(lvl_t lvl);
    return KEY_W'(1) << lvl;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/btmx_ram.sv =====
// Generic single-port RAM with registered read, one access per cycle.
// No dependencies; holds the trie node pool.
`default_nettype none

module btmx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/binary_trie_max_xor.sv =====
// Binary trie maximum-xor engine: top level with node walk sequencer.
// Depends on btmx_pkg and btmx_ram (node pool memory).
//
// Usage: one item on the slave stream carries an operation in tuser
// (clear, insert, query) and a 32-bit key in tdata. Each item yields
// exactly one item on the master stream: best_xor in tdata, status in
// tuser (ok, pool full with insert dropped, query on empty store).
// Timing is set by the single node memory port: one node read or one
// node write per cycle, one trie level per cycle.
//   clear / unused op : straight to the result
//   query             : walk down the trie, one node read per level
//   insert            : walk to first missing level, one parent link write,
//                       then one write per new node
// One item is in work at a time; s_axis_tready is high only when idle.
// A finished result sits in an output register, so the next item is
// accepted while it waits; if the receiver stalls the following result
// holds the sequencer until the register frees up.
// Reset empties the store at once (root marked unwritten, allocator at
// node 1); no clearing pass runs, nodes are zeroed as they are allocated.
`default_nettype none

module binary_trie_max_xor (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input items
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [btmx_pkg::KEY_W-1:0]      s_axis_tdata,  // [31:0] key
  input  wire logic [btmx_pkg::OP_W-1:0]       s_axis_tuser,  // [1:0] op
  // result items
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [btmx_pkg::KEY_W-1:0]      m_axis_tdata,  // [31:0] best_xor
  output logic      [btmx_pkg::STATUS_W-1:0]   m_axis_tuser   // [1:0] status
);

  import btmx_pkg::*;

  localparam lvl_t LVL_TOP = lvl_t'(KEY_BITS - 1);

  state_e            state_q, state_d;
  lvl_t              lvl_q, lvl_d;
  node_idx_t         at_q, at_d;
  node_idx_t         nf_q, nf_d;
  logic [KEY_W-1:0]  key_q, key_d;
  op_e               op_q, op_d;
  logic [KEY_W-1:0]  best_q, best_d;
  status_e           status_q, status_d;
  logic              nonempty_q, nonempty_d;
  logic              root_ok_q, root_ok_d;
  logic [NODE_W-1:0] par_q, par_d;

  logic                out_valid_q;
  logic [KEY_W-1:0]    out_best_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                load_out;

  logic              ram_we;
  node_idx_t         ram_addr;
  logic [NODE_W-1:0] ram_wdata;
  logic [NODE_W-1:0] ram_rdata;

  // Node pool
  btmx_ram #(
    .WIDTH (NODE_W),
    .DEPTH (POOL_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Current node links; an unwritten root reads as empty
  logic [NODE_W-1:0] node;
  node_idx_t         link0, link1;
  logic              kb;
  node_idx_t         nx_same, nx_opp, nx;
  node_idx_t         nf_inc;
  logic              pool_full;

  always_comb begin
    node      = (at_q == '0 && !root_ok_q) ? '0 : ram_rdata;
    link0     = node[NODE_AW-1:0];
    link1     = node[NODE_W-1:NODE_AW];
    kb        = key_bit(key_q, lvl_q);
    nx_same   = kb ? link1 : link0;
    nx_opp    = kb ? link0 : link1;
    nf_inc    = nf_q + node_idx_t'(1);
    pool_full = ({1'b0, nf_q} + (NODE_AW + 1)'(lvl_q) + (NODE_AW + 1)'(1))
                > (NODE_AW + 1)'(POOL_NODES);
  end

  // Sequencer: next state, memory port, result capture
  always_comb begin
    state_d    = state_q;
    lvl_d      = lvl_q;
    at_d       = at_q;
    nf_d       = nf_q;
    key_d      = key_q;
    op_d       = op_q;
    best_d     = best_q;
    status_d   = status_q;
    nonempty_d = nonempty_q;
    root_ok_d  = root_ok_q;
    par_d      = par_q;
    ram_we     = 1'b0;
    ram_addr   = at_q;
    ram_wdata  = '0;
    load_out   = 1'b0;
    nx         = '0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          key_d    = s_axis_tdata;
          op_d     = op_e'(s_axis_tuser);
          lvl_d    = LVL_TOP;
          at_d     = '0;
          best_d   = '0;
          status_d = ST_OK;
          ram_addr = '0;
          case (op_e'(s_axis_tuser))
            OP_CLEAR: begin
              nf_d       = node_idx_t'(1);
              nonempty_d = 1'b0;
              root_ok_d  = 1'b0;
              state_d    = S_DONE;
            end
            OP_INSERT: begin
              state_d = S_WALK;
            end
            OP_QUERY: begin
              if (nonempty_q) begin
                state_d = S_WALK;
              end else begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // One level per cycle, next node read issued here
      S_WALK: begin
        if (op_q == OP_INSERT) begin
          nx = nx_same;
          if (nx != '0) begin
            if (lvl_q == '0) begin
              nonempty_d = 1'b1;
              state_d    = S_DONE;
            end else begin
              at_d     = nx;
              ram_addr = nx;
              lvl_d    = lvl_q - lvl_t'(1);
            end
          end else if (pool_full) begin
            status_d = ST_FULL;
            state_d  = S_DONE;
          end else begin
            par_d   = node;
            state_d = S_LINK;
          end
        end else begin
          if (nx_opp != '0) begin
            nx     = nx_opp;
            best_d = best_q | lvl_mask(lvl_q);
          end else begin
            nx = nx_same;
          end
          if (nx == '0 || lvl_q == '0) begin
            state_d = S_DONE;
          end else begin
            at_d     = nx;
            ram_addr = nx;
            lvl_d    = lvl_q - lvl_t'(1);
          end
        end
      end

      // Hook the first new node into the existing parent
      S_LINK: begin
        ram_we    = 1'b1;
        ram_addr  = at_q;
        ram_wdata = kb ? {nf_q, par_q[NODE_AW-1:0]} : {par_q[NODE_W-1:NODE_AW], nf_q};
        if (at_q == '0) begin
          root_ok_d = 1'b1;
        end
        state_d = S_ALLOC;
      end

      // Write the new chain, each node pointing at the next one
      S_ALLOC: begin
        ram_we   = 1'b1;
        ram_addr = nf_q;
        nf_d     = nf_inc;
        if (lvl_q == '0) begin
          ram_wdata  = '0;
          nonempty_d = 1'b1;
          state_d    = S_DONE;
        end else begin
          if (key_bit(key_q, lvl_q - lvl_t'(1))) begin
            ram_wdata = {nf_inc, {NODE_AW{1'b0}}};
          end else begin
            ram_wdata = {{NODE_AW{1'b0}}, nf_inc};
          end
          lvl_d = lvl_q - lvl_t'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nf_q        <= node_idx_t'(1);
      nonempty_q  <= 1'b0;
      root_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      nf_q       <= nf_d;
      nonempty_q <= nonempty_d;
      root_ok_q  <= root_ok_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk_i) begin
    lvl_q    <= lvl_d;
    at_q     <= at_d;
    key_q    <= key_d;
    op_q     <= op_d;
    best_q   <= best_d;
    status_q <= status_d;
    par_q    <= par_d;
    if (load_out) begin
      out_best_q   <= best_q;
      out_status_q <= status_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_best_q;
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire
